/* rtl/core/bqlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqlp_pkg: shared types, constants and arithmetic helpers
// Fixed-point widths, register indexes, control strobes and saturation logic
// for the three-axis biquad low-pass unit.
// ----------------------------------------------------------------------------
package bqlp_pkg;

  localparam int AXES        = 3;
  localparam int SAMPLE_BITS = 16;

  localparam int COEF_W     = 24;
  localparam int GAIN_W     = 32;
  localparam int DELAY_W    = 48;
  localparam int FRAC_SHIFT = 22;   // coefficient fraction bits
  localparam int Q_FRAC     = 16;   // delay element fraction bits

  // a delay value is split into a signed high part and an unsigned low part
  localparam int HI_W      = DELAY_W - FRAC_SHIFT;
  localparam int LO_W      = FRAC_SHIFT + 1;
  localparam int HI_PROD_W = HI_W + COEF_W;
  localparam int LO_PROD_W = LO_W + COEF_W;
  localparam int TERM_W    = DELAY_W + COEF_W - FRAC_SHIFT + 1;
  localparam int SUM_W     = TERM_W + 2;
  localparam int PRIME_W   = SAMPLE_BITS + GAIN_W + 1;
  localparam int RND_W     = SUM_W - Q_FRAC;

  localparam int IN_DATA_W  = ((AXES * SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((AXES * SAMPLE_BITS + 7) / 8) * 8;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [CFG_ADDR_W-1:0] CFG_B0   = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] CFG_B1   = CFG_ADDR_W'(1);
  localparam logic [CFG_ADDR_W-1:0] CFG_B2   = CFG_ADDR_W'(2);
  localparam logic [CFG_ADDR_W-1:0] CFG_A1   = CFG_ADDR_W'(3);
  localparam logic [CFG_ADDR_W-1:0] CFG_A2   = CFG_ADDR_W'(4);
  localparam logic [CFG_ADDR_W-1:0] CFG_GAIN = CFG_ADDR_W'(5);

  localparam logic signed [COEF_W-1:0] B0_RESET   = COEF_W'(4194304);
  localparam logic [GAIN_W-1:0]        GAIN_RESET = GAIN_W'(65536);

  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [GAIN_W-1:0]        gain;
  } cfg_t;

  // per-cycle strobes from the sequencer to every lane
  typedef struct packed {
    logic load;
    logic mul_fb;
    logic prime;
    logic sum_w0;
    logic mul_ff;
    logic commit;
  } ctrl_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PRIME  = 6'b000010,
    ST_MUL_FB = 6'b000100,
    ST_SUM_W0 = 6'b001000,
    ST_MUL_FF = 6'b010000,
    ST_SUM_Y  = 6'b100000
  } state_t;

  typedef struct packed {
    logic signed [DELAY_W-1:0] value;
    logic                      clip;
  } sat_delay_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          clip;
  } sat_out_t;

  function automatic logic signed [HI_PROD_W-1:0] mul_hi(
    input logic signed [DELAY_W-1:0] d,
    input logic signed [COEF_W-1:0]  c
  );
    logic signed [HI_W-1:0]      h;
    logic signed [HI_PROD_W-1:0] p;
    h = d[DELAY_W-1:FRAC_SHIFT];
    p = h * c;
    return p;
  endfunction

  function automatic logic signed [LO_PROD_W-1:0] mul_lo(
    input logic signed [DELAY_W-1:0] d,
    input logic signed [COEF_W-1:0]  c
  );
    logic signed [LO_W-1:0]      l;
    logic signed [LO_PROD_W-1:0] p;
    l = $signed({1'b0, d[FRAC_SHIFT-1:0]});
    p = l * c;
    return p;
  endfunction

  // floor(d*c / 2^22) rebuilt from the two partial products
  function automatic logic signed [TERM_W-1:0] q22_term(
    input logic signed [HI_PROD_W-1:0] hp,
    input logic signed [LO_PROD_W-1:0] lp
  );
    logic signed [LO_PROD_W-1:0] ls;
    ls = lp >>> FRAC_SHIFT;
    return TERM_W'(hp) + TERM_W'(ls);
  endfunction

  function automatic sat_delay_t sat_delay(input logic signed [SUM_W-1:0] v);
    sat_delay_t r;
    r.clip = (v[SUM_W-1:DELAY_W-1] != {(SUM_W-DELAY_W+1){1'b0}}) &&
             (v[SUM_W-1:DELAY_W-1] != {(SUM_W-DELAY_W+1){1'b1}});
    if (!r.clip) begin
      r.value = v[DELAY_W-1:0];
    end else if (v[SUM_W-1]) begin
      r.value = {1'b1, {(DELAY_W-1){1'b0}}};
    end else begin
      r.value = {1'b0, {(DELAY_W-1){1'b1}}};
    end
    return r;
  endfunction

  // floor to integer, then clip to the sample range; the caller adds the half-up rounding offset
  function automatic sat_out_t sat_out(input logic signed [SUM_W-1:0] v);
    logic signed [RND_W-1:0] q;
    sat_out_t                r;
    q = RND_W'(v >>> Q_FRAC);
    r.clip = (q[RND_W-1:SAMPLE_BITS-1] != {(RND_W-SAMPLE_BITS+1){1'b0}}) &&
             (q[RND_W-1:SAMPLE_BITS-1] != {(RND_W-SAMPLE_BITS+1){1'b1}});
    if (!r.clip) begin
      r.value = q[SAMPLE_BITS-1:0];
    end else if (q[RND_W-1]) begin
      r.value = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      r.value = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

/* rtl/core/bqlp_lane.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqlp_lane: one axis of the biquad
// Holds the two delay elements of its axis and runs the feedback sum, the
// feed-forward sum and the priming product under sequencer strobes.
// ----------------------------------------------------------------------------
module bqlp_lane (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  bqlp_pkg::ctrl_t                             ctrl,
  input  bqlp_pkg::cfg_t                              cfg,
  input  logic signed [bqlp_pkg::SAMPLE_BITS-1:0]     sample,
  output logic signed [bqlp_pkg::SAMPLE_BITS-1:0]     y,
  output logic                                        clip
);

  logic signed [bqlp_pkg::SAMPLE_BITS-1:0] s_r;
  logic signed [bqlp_pkg::DELAY_W-1:0]     d1_r;
  logic signed [bqlp_pkg::DELAY_W-1:0]     d2_r;
  logic signed [bqlp_pkg::DELAY_W-1:0]     w0_r;
  logic                                    flag_r;

  logic signed [bqlp_pkg::HI_PROD_W-1:0] a1h_r, b1h_r, a2h_r, b2h_r, b0h_r;
  logic signed [bqlp_pkg::LO_PROD_W-1:0] a1l_r, b1l_r, a2l_r, b2l_r, b0l_r;

  logic signed [bqlp_pkg::GAIN_W:0]    gain_s;
  logic signed [bqlp_pkg::PRIME_W-1:0] prime_prod;
  bqlp_pkg::sat_delay_t                prime_sat;
  logic signed [bqlp_pkg::SUM_W-1:0]   fb_sum;
  bqlp_pkg::sat_delay_t                w0_sat;
  logic signed [bqlp_pkg::SUM_W-1:0]   y_sum;
  bqlp_pkg::sat_out_t                  y_sat;

  always_comb begin
    gain_s     = $signed({1'b0, cfg.gain});
    prime_prod = s_r * gain_s;
    prime_sat  = bqlp_pkg::sat_delay(bqlp_pkg::SUM_W'(prime_prod));

    fb_sum = (bqlp_pkg::SUM_W'(s_r) <<< bqlp_pkg::Q_FRAC)
           - bqlp_pkg::SUM_W'(bqlp_pkg::q22_term(a1h_r, a1l_r))
           - bqlp_pkg::SUM_W'(bqlp_pkg::q22_term(a2h_r, a2l_r));
    w0_sat = bqlp_pkg::sat_delay(fb_sum);

    y_sum = bqlp_pkg::SUM_W'(bqlp_pkg::q22_term(b0h_r, b0l_r))
          + bqlp_pkg::SUM_W'(bqlp_pkg::q22_term(b1h_r, b1l_r))
          + bqlp_pkg::SUM_W'(bqlp_pkg::q22_term(b2h_r, b2l_r))
          + (bqlp_pkg::SUM_W'(1) <<< (bqlp_pkg::Q_FRAC - 1));
    y_sat = bqlp_pkg::sat_out(y_sum);

    y    = y_sat.value;
    clip = flag_r | y_sat.clip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_r   <= '0;
      d2_r   <= '0;
      flag_r <= 1'b0;
    end else begin
      if (ctrl.prime) begin
        d1_r <= prime_sat.value;
        d2_r <= prime_sat.value;
      end else if (ctrl.commit) begin
        d2_r <= d1_r;
        d1_r <= w0_r;
      end
      if (ctrl.load) begin
        flag_r <= 1'b0;
      end else if (ctrl.prime) begin
        flag_r <= flag_r | prime_sat.clip;
      end else if (ctrl.sum_w0) begin
        flag_r <= flag_r | w0_sat.clip;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      s_r <= sample;
    end
    // d1 and d2 products for both the feedback and the feed-forward taps
    if (ctrl.mul_fb) begin
      a1h_r <= bqlp_pkg::mul_hi(d1_r, cfg.a1);
      a1l_r <= bqlp_pkg::mul_lo(d1_r, cfg.a1);
      b1h_r <= bqlp_pkg::mul_hi(d1_r, cfg.b1);
      b1l_r <= bqlp_pkg::mul_lo(d1_r, cfg.b1);
      a2h_r <= bqlp_pkg::mul_hi(d2_r, cfg.a2);
      a2l_r <= bqlp_pkg::mul_lo(d2_r, cfg.a2);
      b2h_r <= bqlp_pkg::mul_hi(d2_r, cfg.b2);
      b2l_r <= bqlp_pkg::mul_lo(d2_r, cfg.b2);
    end
    if (ctrl.sum_w0) begin
      w0_r <= w0_sat.value;
    end
    if (ctrl.mul_ff) begin
      b0h_r <= bqlp_pkg::mul_hi(w0_r, cfg.b0);
      b0l_r <= bqlp_pkg::mul_lo(w0_r, cfg.b0);
    end
  end

endmodule

/* rtl/core/bqlp_merge.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqlp_merge: result merge and output register
// Packs the lane outputs into one result, folds the lane clip flags into a
// single flag and holds the result until the downstream side takes it.
// ----------------------------------------------------------------------------
module bqlp_merge (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    load,
  input  logic signed [bqlp_pkg::SAMPLE_BITS-1:0] lane_y [bqlp_pkg::AXES],
  input  logic [bqlp_pkg::AXES-1:0]               lane_clip,
  output logic                                    room,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  output logic [bqlp_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                    out_tuser
);

  logic                               valid_r;
  logic [bqlp_pkg::OUT_DATA_W-1:0]    data_r;
  logic [bqlp_pkg::OUT_DATA_W-1:0]    data_nxt;
  logic                               flag_r;

  always_comb begin
    data_nxt = '0;
    for (int i = 0; i < bqlp_pkg::AXES; i++) begin
      data_nxt[i*bqlp_pkg::SAMPLE_BITS +: bqlp_pkg::SAMPLE_BITS] = lane_y[i];
    end
  end

  assign room       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = flag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= data_nxt;
      flag_r <= |lane_clip;
    end
  end

endmodule

/* rtl/core/three_axis_biquad_lowpass_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_biquad_lowpass_unit: three-axis second-order low-pass filter
// Direct form II biquad per axis with shared coefficients; one lane per axis.
// Requests are taken only in the idle state, one at a time; each runs the loop
//   feedback multiply -> w0 sum -> b0 multiply -> output sum and delay update,
//   after a priming step when in_tuser is set, and waits there for output room.
// Reset: synchronous, active low; delays clear, coefficients return to b0=1.0,
//   others 0, prime gain 1.0; no clearing pass.
// ----------------------------------------------------------------------------
module three_axis_biquad_lowpass_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: sample_x, sample_y, sample_z
  input  logic [bqlp_pkg::IN_DATA_W-1:0]      in_tdata,
  // in_tuser: cmd
  input  logic                                in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata: filtered_x, filtered_y, filtered_z
  output logic [bqlp_pkg::OUT_DATA_W-1:0]     out_tdata,
  // out_tuser: saturated
  output logic                                out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [bqlp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bqlp_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  bqlp_pkg::cfg_t   cfg_r;
  bqlp_pkg::state_t state_r;
  bqlp_pkg::state_t state_nxt;
  bqlp_pkg::ctrl_t  ctrl;
  logic             accept;
  logic             room;

  logic signed [bqlp_pkg::SAMPLE_BITS-1:0] lane_y [bqlp_pkg::AXES];
  logic [bqlp_pkg::AXES-1:0]               lane_clip;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.b0   <= bqlp_pkg::B0_RESET;
      cfg_r.b1   <= '0;
      cfg_r.b2   <= '0;
      cfg_r.a1   <= '0;
      cfg_r.a2   <= '0;
      cfg_r.gain <= bqlp_pkg::GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        bqlp_pkg::CFG_B0:   cfg_r.b0   <= $signed(cfg_wdata[bqlp_pkg::COEF_W-1:0]);
        bqlp_pkg::CFG_B1:   cfg_r.b1   <= $signed(cfg_wdata[bqlp_pkg::COEF_W-1:0]);
        bqlp_pkg::CFG_B2:   cfg_r.b2   <= $signed(cfg_wdata[bqlp_pkg::COEF_W-1:0]);
        bqlp_pkg::CFG_A1:   cfg_r.a1   <= $signed(cfg_wdata[bqlp_pkg::COEF_W-1:0]);
        bqlp_pkg::CFG_A2:   cfg_r.a2   <= $signed(cfg_wdata[bqlp_pkg::COEF_W-1:0]);
        bqlp_pkg::CFG_GAIN: cfg_r.gain <= cfg_wdata[bqlp_pkg::GAIN_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  assign in_tready = (state_r == bqlp_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // a plain filter request starts its feedback multiplies on the accept edge
  always_comb begin
    ctrl.load   = accept;
    ctrl.mul_fb = (accept && !in_tuser) || (state_r == bqlp_pkg::ST_MUL_FB);
    ctrl.prime  = (state_r == bqlp_pkg::ST_PRIME);
    ctrl.sum_w0 = (state_r == bqlp_pkg::ST_SUM_W0);
    ctrl.mul_ff = (state_r == bqlp_pkg::ST_MUL_FF);
    ctrl.commit = (state_r == bqlp_pkg::ST_SUM_Y) && room;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bqlp_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = in_tuser ? bqlp_pkg::ST_PRIME : bqlp_pkg::ST_SUM_W0;
        end
      end
      bqlp_pkg::ST_PRIME:  state_nxt = bqlp_pkg::ST_MUL_FB;
      bqlp_pkg::ST_MUL_FB: state_nxt = bqlp_pkg::ST_SUM_W0;
      bqlp_pkg::ST_SUM_W0: state_nxt = bqlp_pkg::ST_MUL_FF;
      bqlp_pkg::ST_MUL_FF: state_nxt = bqlp_pkg::ST_SUM_Y;
      bqlp_pkg::ST_SUM_Y: begin
        if (room) begin
          state_nxt = bqlp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bqlp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bqlp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  for (genvar i = 0; i < bqlp_pkg::AXES; i++) begin : g_lane
    bqlp_lane u_lane (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .cfg    (cfg_r),
      .sample ($signed(in_tdata[i*bqlp_pkg::SAMPLE_BITS +: bqlp_pkg::SAMPLE_BITS])),
      .y      (lane_y[i]),
      .clip   (lane_clip[i])
    );
  end

  bqlp_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (ctrl.commit),
    .lane_y     (lane_y),
    .lane_clip  (lane_clip),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* verif/three_axis_biquad_lowpass_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_axis_biquad_lowpass_unit_tb: self-checking bench for the biquad unit
// Streams filter and prime requests with random source gaps and sink stalls.
// A bit-exact fixed-point copy of the filter predicts every result, which is
// checked per axis and for the clip flag. Coefficient sets change between
// phases: reset values, a nominal low-pass, extremes and random sets.
// ----------------------------------------------------------------------------
module three_axis_biquad_lowpass_unit_tb;
  import bqlp_pkg::*;

  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_PRIME  = 1'b1;

  // indexes past the register file, writes there must be dropped
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_LO = CFG_ADDR_W'(6);
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_HI = CFG_ADDR_W'(7);

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 12;

  // nominal 2nd-order Butterworth, fc = fs/10, taps in Q2.22, gain Q16.16
  localparam int LP_B0   = 282929;
  localparam int LP_B1   = 565858;
  localparam int LP_B2   = 282929;
  localparam int LP_A1   = -4794009;
  localparam int LP_A2   = 1731398;
  localparam int LP_GAIN = 242887;

  localparam logic [CFG_DATA_W-1:0] TAP_MAX  = CFG_DATA_W'(24'h7FFFFF);
  localparam logic [CFG_DATA_W-1:0] TAP_MIN  = CFG_DATA_W'(24'h800000);
  localparam logic [CFG_DATA_W-1:0] GAIN_MAX = {CFG_DATA_W{1'b1}};

  localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef logic signed [79:0] acc_t;
  typedef logic signed [SAMPLE_BITS-1:0] smp_t;

  localparam acc_t DLY_MAX  = (acc_t'(1) <<< (DELAY_W - 1)) - 1;
  localparam acc_t DLY_MIN  = -(acc_t'(1) <<< (DELAY_W - 1));
  localparam acc_t OUT_MAX  = (acc_t'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam acc_t OUT_MIN  = -(acc_t'(1) <<< (SAMPLE_BITS - 1));
  localparam acc_t HALF_LSB = acc_t'(1) <<< (Q_FRAC - 1);

  typedef struct packed {
    logic [AXES-1:0][SAMPLE_BITS-1:0] axis;
    logic                             clip;
  } filt_result_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic                  in_tuser  = CMD_FILTER;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  // shadow of the unit: coefficients indexed by register index, delay lines
  logic signed [COEF_W-1:0]  coef_reg [5];
  logic [GAIN_W-1:0]         gain_reg;
  logic signed [DELAY_W-1:0] dly1 [AXES];
  logic signed [DELAY_W-1:0] dly2 [AXES];

  filt_result_t filtered_q [$];
  filt_result_t want;

  bit          quiet = 1'b0;
  int          hold_left = 0;
  int          idle_cycles = 0;
  int unsigned n_errors = 0;
  int unsigned n_requests = 0;
  int unsigned n_primes = 0;
  int unsigned n_results = 0;
  int unsigned n_clipped = 0;
  int unsigned n_writes = 0;

  three_axis_biquad_lowpass_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // floor(d * c / 2^22), exact in the wide accumulator
  function automatic acc_t q22_product(input logic signed [DELAY_W-1:0] d,
                                       input logic signed [COEF_W-1:0] c);
    acc_t p;
    p = d * c;
    return p >>> FRAC_SHIFT;
  endfunction

  function automatic acc_t clamp(input acc_t v, input acc_t lo, input acc_t hi,
                                 inout logic hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic filt_result_t biquad_step(input logic cmd,
                                               input logic [IN_DATA_W-1:0] data);
    filt_result_t res;
    acc_t         s;
    acc_t         w0;
    acc_t         y;
    acc_t         r;
    logic         hit;
    hit = 1'b0;
    for (int i = 0; i < AXES; i++) begin
      s = $signed(data[i*SAMPLE_BITS +: SAMPLE_BITS]);
      if (cmd == CMD_PRIME) begin
        w0 = clamp(s * $signed({1'b0, gain_reg}), DLY_MIN, DLY_MAX, hit);
        dly1[i] = w0[DELAY_W-1:0];
        dly2[i] = w0[DELAY_W-1:0];
      end
      w0 = (s <<< Q_FRAC) - q22_product(dly1[i], coef_reg[CFG_A1])
                          - q22_product(dly2[i], coef_reg[CFG_A2]);
      w0 = clamp(w0, DLY_MIN, DLY_MAX, hit);
      y  = q22_product(w0[DELAY_W-1:0], coef_reg[CFG_B0])
         + q22_product(dly1[i], coef_reg[CFG_B1])
         + q22_product(dly2[i], coef_reg[CFG_B2]);
      r  = clamp((y + HALF_LSB) >>> Q_FRAC, OUT_MIN, OUT_MAX, hit);
      dly2[i] = dly1[i];
      dly1[i] = w0[DELAY_W-1:0];
      res.axis[i] = r[SAMPLE_BITS-1:0];
    end
    res.clip = hit;
    return res;
  endfunction

  // ---------------------------------------------------------------- drivers

  task automatic send_request(input logic cmd, input smp_t sx, input smp_t sy,
                              input smp_t sz);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < 20) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {sz, sy, sx};
    do @(posedge clk); while (!in_tready);
    filtered_q.push_back(biquad_step(cmd, {sz, sy, sx}));
    n_requests++;
    if (cmd == CMD_PRIME) n_primes++;
  endtask

  // stop the source and let every outstanding result come back
  task automatic settle();
    in_tvalid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_B0, CFG_B1, CFG_B2, CFG_A1, CFG_A2: coef_reg[idx] = val[COEF_W-1:0];
      CFG_GAIN: gain_reg = val[GAIN_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  // tap writes carry junk above bit 23, the unit must drop it
  task automatic load_filter(input logic [CFG_DATA_W-1:0] b0, input logic [CFG_DATA_W-1:0] b1,
                             input logic [CFG_DATA_W-1:0] b2, input logic [CFG_DATA_W-1:0] a1,
                             input logic [CFG_DATA_W-1:0] a2, input logic [CFG_DATA_W-1:0] gain);
    write_reg(CFG_B0, {8'($urandom), b0[COEF_W-1:0]});
    write_reg(CFG_B1, {8'($urandom), b1[COEF_W-1:0]});
    write_reg(CFG_B2, {8'($urandom), b2[COEF_W-1:0]});
    write_reg(CFG_A1, {8'($urandom), a1[COEF_W-1:0]});
    write_reg(CFG_A2, {8'($urandom), a2[COEF_W-1:0]});
    write_reg(CFG_GAIN, gain);
    cfg_we <= 1'b0;
  endtask

  function automatic smp_t rand_sample();
    case ($urandom_range(0, 9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2, 3:    return smp_t'($urandom_range(0, 511) - 256);
      default: return smp_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_extreme_tap();
    case ($urandom_range(0, 2))
      0:       return TAP_MAX;
      1:       return TAP_MIN;
      default: return '0;
    endcase
  endfunction

  // ---------------------------------------------------------------- tests

  // reset taps make the unit a pass-through, priming included
  task automatic test_passthrough();
    send_request(CMD_FILTER, SMP_MAX, SMP_MIN, 0);
    send_request(CMD_FILTER, SMP_MIN, SMP_MAX, -1);
    send_request(CMD_FILTER, 1, -1, 16'sh5555);
    send_request(CMD_PRIME, SMP_MAX, SMP_MIN, 1234);
    send_request(CMD_FILTER, 0, 0, 0);
    settle();
    write_reg(CFG_UNUSED_LO, GAIN_MAX);
    write_reg(CFG_UNUSED_HI, GAIN_MAX);
    cfg_we <= 1'b0;
    send_request(CMD_FILTER, -200, 300, SMP_MAX);
    send_request(CMD_FILTER, SMP_MIN, 77, -77);
    settle();
  endtask

  // priming puts the delays at steady state, a constant input stays flat
  task automatic test_lowpass_prime();
    load_filter(LP_B0, LP_B1, LP_B2, LP_A1, LP_A2, LP_GAIN);
    send_request(CMD_PRIME, 1000, -1000, SMP_MAX);
    repeat (2) send_request(CMD_FILTER, 1000, -1000, SMP_MAX);
    repeat (2) send_request(CMD_FILTER, SMP_MIN, SMP_MIN, SMP_MIN);
    settle();
  endtask

  // b0 near +/-2.0 drives the rounded output past the sample range
  task automatic test_output_clip();
    load_filter(TAP_MAX, 0, 0, 0, 0, GAIN_MAX);
    send_request(CMD_FILTER, SMP_MAX, SMP_MIN, 16384);
    send_request(CMD_PRIME, 16383, 16384, -16385);
    settle();
    load_filter(TAP_MIN, 0, 0, 0, 0, 0);
    send_request(CMD_FILTER, SMP_MIN, SMP_MAX, 0);
    send_request(CMD_PRIME, SMP_MAX, -1, 1);
    settle();
  endtask

  // feedback taps at -2.0 with a full-scale primed state: delay clips at once
  task automatic test_delay_clip();
    load_filter(TAP_MAX, TAP_MIN, TAP_MAX, TAP_MIN, TAP_MIN, GAIN_MAX);
    send_request(CMD_PRIME, SMP_MAX, SMP_MIN, 100);
    repeat (5) send_request(CMD_FILTER, rand_sample(), rand_sample(), rand_sample());
    settle();
  endtask

  task automatic test_random_phase(input int count);
    case ($urandom_range(0, 3))
      0: load_filter(LP_B0, LP_B1, LP_B2, LP_A1, LP_A2, LP_GAIN);
      1: load_filter(LP_B0 + $urandom_range(0, 4000) - 2000,
                     LP_B1 + $urandom_range(0, 4000) - 2000,
                     LP_B2 + $urandom_range(0, 4000) - 2000,
                     LP_A1 + $urandom_range(0, 4000) - 2000,
                     LP_A2 + $urandom_range(0, 4000) - 2000,
                     LP_GAIN + $urandom_range(0, 4000) - 2000);
      2: load_filter($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      default: load_filter(rand_extreme_tap(), rand_extreme_tap(), rand_extreme_tap(),
                           rand_extreme_tap(), rand_extreme_tap(),
                           ($urandom_range(0, 1) != 0) ? GAIN_MAX : '0);
    endcase
    for (int k = 0; k < count; k++) begin
      send_request(($urandom_range(0, 99) < 8) ? CMD_PRIME : CMD_FILTER,
                   rand_sample(), rand_sample(), rand_sample());
    end
    settle();
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (filtered_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got data %h flag %b",
                 $time, out_tdata, out_tuser);
        n_errors++;
      end else begin
        want = filtered_q.pop_front();
        if (want.clip) n_clipped++;
        for (int i = 0; i < AXES; i++) begin
          if (out_tdata[i*SAMPLE_BITS +: SAMPLE_BITS] !== want.axis[i]) begin
            $display("%0t: axis %0d mismatch, expected %0d, got %0d", $time, i,
                     $signed(want.axis[i]),
                     $signed(out_tdata[i*SAMPLE_BITS +: SAMPLE_BITS]));
            n_errors++;
          end
        end
        if (out_tuser !== want.clip) begin
          $display("%0t: clip flag mismatch, expected %b, got %b",
                   $time, want.clip, out_tuser);
          n_errors++;
        end
      end
    end
  end

  // sink back-pressure in random bursts
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 15) begin
      hold_left  <= $urandom_range(0, 13);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_cycles);
      $display("three_axis_biquad_lowpass_unit_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    coef_reg[CFG_B0] = B0_RESET;
    coef_reg[CFG_B1] = '0;
    coef_reg[CFG_B2] = '0;
    coef_reg[CFG_A1] = '0;
    coef_reg[CFG_A2] = '0;
    gain_reg         = GAIN_RESET;
    for (int i = 0; i < AXES; i++) begin
      dly1[i] = '0;
      dly2[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_passthrough();
    test_lowpass_prime();
    test_output_clip();
    test_delay_clip();
    for (int p = 0; p < 6; p++) test_random_phase(100);
    quiet = 1'b1;
    test_random_phase(100);

    $display("run covered %0d requests (%0d priming) and %0d results, %0d of them clipped,",
             n_requests, n_primes, n_results, n_clipped);
    $display("across %0d register writes incl. dropped out-of-range indexes",
             n_writes);
    if (n_errors == 0) begin
      $display("three_axis_biquad_lowpass_unit_tb: clean");
    end else begin
      $display("three_axis_biquad_lowpass_unit_tb: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/bqlp_pkg.sv
rtl/core/bqlp_lane.sv
rtl/core/bqlp_merge.sv
rtl/core/three_axis_biquad_lowpass_unit.sv
verif/three_axis_biquad_lowpass_unit_tb.sv
